FILE: hw/rtl/wppi_pkg.sv
package wppi_pkg;

   // Controller modes, as reported in the response word
   typedef enum logic [1:0] {
      MODE_ORIENT = 2'd0,
      MODE_MOVE   = 2'd1,
      MODE_GOAL   = 2'd2
   } mode_type;

   // CSR indexes
   localparam logic [2:0] CSR_KP_HEADING  = 3'd0;
   localparam logic [2:0] CSR_KI_HEADING  = 3'd1;
   localparam logic [2:0] CSR_KP_DISTANCE = 3'd2;
   localparam logic [2:0] CSR_KI_DISTANCE = 3'd3;
   localparam logic [2:0] CSR_HEAD_TOL    = 3'd4;
   localparam logic [2:0] CSR_DIST_TOL    = 3'd5;
   localparam logic [2:0] CSR_YAW_SCALE   = 3'd6;
   localparam logic [2:0] CSR_FINAL_WP    = 3'd7;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_ODOM = 1'b1;

   localparam int CORDIC_STEPS = 17;
   localparam int SQRT_STEPS   = 18;
   localparam logic signed [20:0] ANG_PI_Q16 = 21'sd205887;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RD0,
      ST_RDT,
      ST_DIFF,
      ST_THETA,
      ST_CINIT,
      ST_CORDIC,
      ST_ERR,
      ST_ORCHK,
      ST_SQX,
      ST_SQY,
      ST_SQINIT,
      ST_SQRT,
      ST_DMOVE,
      ST_HP,
      ST_HI,
      ST_HOUT,
      ST_DP,
      ST_DI,
      ST_DOUT,
      ST_GOAL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               op;
      logic [2:0]         load_index;
      logic signed [15:0] load_x;
      logic signed [15:0] load_y;
      logic signed [15:0] odom_x;
      logic signed [15:0] odom_y;
      logic signed [15:0] odom_qz;
   } req_type;

   typedef struct packed {
      logic signed [15:0] linear_cmd;
      logic signed [15:0] angular_cmd;
      logic [1:0]         mode;
      logic [2:0]         target_index;
   } rsp_type;

   // atan(2^-i) in 2^-16 rad
   function automatic logic [16:0] atan_lut(input logic [4:0] i);
      logic [16:0] v;
      case (i)
         5'd0:    v = 17'd51472;
         5'd1:    v = 17'd30386;
         5'd2:    v = 17'd16055;
         5'd3:    v = 17'd8150;
         5'd4:    v = 17'd4091;
         5'd5:    v = 17'd2047;
         5'd6:    v = 17'd1024;
         5'd7:    v = 17'd512;
         5'd8:    v = 17'd256;
         5'd9:    v = 17'd128;
         5'd10:   v = 17'd64;
         5'd11:   v = 17'd32;
         5'd12:   v = 17'd16;
         5'd13:   v = 17'd8;
         5'd14:   v = 17'd4;
         5'd15:   v = 17'd2;
         5'd16:   v = 17'd1;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v > 33'sd2147483647)       r = 32'sh7fffffff;
      else if (v < -33'sd2147483648) r = 32'sh80000000;
      else                           r = v[31:0];
      return r;
   endfunction

   // round half up by 2^16, then clamp to 16 bits
   function automatic logic signed [15:0] rnd_sat16(input logic signed [59:0] acc);
      logic signed [60:0] t;
      logic signed [44:0] s;
      logic signed [15:0] r;
      t = 61'(acc) + 61'sd32768;
      s = 45'(t >>> 16);
      if (s > 45'sd32767)       r = 16'sh7fff;
      else if (s < -45'sd32768) r = 16'sh8000;
      else                      r = s[15:0];
      return r;
   endfunction

endpackage

FILE: hw/rtl/waypoint_pi_path_controller_top.sv
// Waypoint-following PI controller. A request word either loads one route
// entry (op 0, no response) or carries an odometry sample (op 1, exactly one
// response word). Each sample is worked by a small sequencer around one
// shared 25x33 multiply-accumulate unit, an iterative 17-step CORDIC for
// atan2 and an 18-step bit-pair square root. Orient mode computes a turn
// command unless the heading lines up, move mode computes both commands
// unless the target is reached, and goal mode answers with zero commands;
// the next request can be taken in the cycle after the response is loaded.
// A route load is written straight into the route memory and leaves the
// sequencer idle. The sequencer holds one sample at a time, so req_ready is
// low while it works; a finished response sits in an output register and
// the next request is taken meanwhile.
// CSRs may only be written while the block is idle.
module waypoint_pi_path_controller_top
   import wppi_pkg::*;
#(
   parameter int MAX_WAYPOINTS = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [23:0]   csr_data
);

   localparam int IDX_W = $clog2(MAX_WAYPOINTS);

   // ---------------- CSRs ----------------
   logic [23:0] kp_h_ff, ki_h_ff, kp_d_ff, ki_d_ff;
   logic [14:0] htol_ff, dtol_ff, yaw_ff;
   logic [2:0]  final_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_h_ff  <= 24'd65536;
         ki_h_ff  <= 24'd33;
         kp_d_ff  <= 24'd6554;
         ki_d_ff  <= 24'd1;
         htol_ff  <= 15'd4;
         dtol_ff  <= 15'd13;
         yaw_ff   <= 15'd8970;
         final_ff <= 3'd4;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_KP_HEADING:  kp_h_ff  <= csr_data;
            CSR_KI_HEADING:  ki_h_ff  <= csr_data;
            CSR_KP_DISTANCE: kp_d_ff  <= csr_data;
            CSR_KI_DISTANCE: ki_d_ff  <= csr_data;
            CSR_HEAD_TOL:    htol_ff  <= csr_data[14:0];
            CSR_DIST_TOL:    dtol_ff  <= csr_data[14:0];
            CSR_YAW_SCALE:   yaw_ff   <= csr_data[14:0];
            CSR_FINAL_WP:    final_ff <= csr_data[2:0];
            default:         ;
         endcase
      end
   end

   // ---------------- state ----------------
   state_type state_ff, state_in;
   req_type   req_ff;
   logic      req_fire, rsp_load;

   logic [31:0]        route_mem [MAX_WAYPOINTS];
   logic [31:0]        rd_data_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;

   logic signed [16:0] px_ff, py_ff;
   logic signed [17:0] dx_ff, dy_ff;
   logic signed [17:0] theta_ff;
   logic signed [33:0] cx_ff, cy_ff;
   logic signed [20:0] cz_ff;
   logic               zero_ff;
   logic [4:0]         iter_ff;
   logic signed [18:0] err_ff;
   logic signed [59:0] acc_ff;
   logic [35:0]        sq_v_ff, sq_r_ff, sq_bit_ff;
   logic [18:0]        dist_ff;
   logic signed [31:0] hint_ff, dint_ff;
   mode_type           mode_ff;
   logic [IDX_W-1:0]   target_ff;
   logic signed [15:0] lin_ff, ang_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   assign req_fire = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- shared MAC ----------------
   logic signed [24:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [57:0] mul_p;
   assign mul_p = mul_a * mul_b;

   // ---------------- step logic ----------------
   logic signed [33:0] cx_sh, cy_sh;
   logic signed [20:0] atan_v, zq;
   logic signed [18:0] err_c, mag_c;
   logic [35:0]        sq_try;
   logic               last_iter, at_final;
   logic [IDX_W-1:0]   target_next;

   assign cx_sh     = cx_ff >>> iter_ff;
   assign cy_sh     = cy_ff >>> iter_ff;
   assign atan_v    = 21'($signed({1'b0, atan_lut(iter_ff)}));
   assign zq        = 21'((cz_ff + 21'sd8) >>> 4);
   assign err_c     = (zero_ff ? 19'sd0 : 19'(zq)) - 19'(theta_ff);
   assign mag_c     = err_ff[18] ? -err_ff : err_ff;
   assign sq_try    = sq_r_ff + sq_bit_ff;
   assign at_final  = (9'(target_ff) == 9'(final_ff));
   assign target_next = (32'(target_ff) == MAX_WAYPOINTS - 1) ? '0 : target_ff + 1'b1;
   assign last_iter = (state_ff == ST_CORDIC) ? (iter_ff == 5'(CORDIC_STEPS - 1))
                                              : (iter_ff == 5'(SQRT_STEPS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_data.op == OP_ODOM)
               state_in = (mode_ff == MODE_ORIENT || mode_ff == MODE_MOVE) ? ST_RD0 : ST_GOAL;
         end
         ST_RD0:    state_in = ST_RDT;
         ST_RDT:    state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_THETA;
         ST_THETA:  state_in = ST_CINIT;
         ST_CINIT:  state_in = ST_CORDIC;
         ST_CORDIC: if (last_iter) state_in = ST_ERR;
         ST_ERR:    state_in = (mode_ff == MODE_ORIENT) ? ST_ORCHK : ST_SQX;
         ST_ORCHK:  state_in = (19'(htol_ff) > mag_c) ? ST_DONE : ST_HP;
         ST_SQX:    state_in = ST_SQY;
         ST_SQY:    state_in = ST_SQINIT;
         ST_SQINIT: state_in = ST_SQRT;
         ST_SQRT:   if (last_iter) state_in = ST_DMOVE;
         ST_DMOVE:  state_in = (19'(dtol_ff) > dist_ff) ? ST_DONE : ST_HP;
         ST_HP:     state_in = ST_HI;
         ST_HI:     state_in = ST_HOUT;
         ST_HOUT:   state_in = (mode_ff == MODE_MOVE) ? ST_DP : ST_DONE;
         ST_DP:     state_in = ST_DI;
         ST_DI:     state_in = ST_DOUT;
         ST_DOUT:   state_in = ST_DONE;
         ST_GOAL:   state_in = ST_DONE;
         ST_DONE:   if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs and MAC operand select
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
      wr_en     = req_fire && req_data.op == OP_LOAD &&
                  ({6'd0, req_data.load_index} < 9'(MAX_WAYPOINTS));
      rd_addr   = (state_ff == ST_RD0) ? '0 : target_ff;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         ST_THETA: begin
            mul_a = 25'(req_ff.odom_qz);
            mul_b = 33'($signed({1'b0, yaw_ff}));
         end
         ST_SQX: begin
            mul_a = 25'(dx_ff);
            mul_b = 33'(dx_ff);
         end
         ST_SQY: begin
            mul_a = 25'(dy_ff);
            mul_b = 33'(dy_ff);
         end
         ST_HP: begin
            mul_a = $signed({1'b0, kp_h_ff});
            mul_b = 33'(err_ff);
         end
         ST_HI: begin
            mul_a = $signed({1'b0, ki_h_ff});
            mul_b = 33'(hint_ff);
         end
         ST_DP: begin
            mul_a = $signed({1'b0, kp_d_ff});
            mul_b = 33'($signed({1'b0, dist_ff}));
         end
         ST_DI: begin
            mul_a = $signed({1'b0, ki_d_ff});
            mul_b = 33'(dint_ff);
         end
         default: ;
      endcase
   end

   // route memory
   always_ff @(posedge clock) begin
      if (wr_en)
         route_mem[IDX_W'(req_data.load_index)] <= {req_data.load_x, req_data.load_y};
      rd_data_ff <= route_mem[rd_addr];
   end

   // sequencer control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_ORIENT;
         target_ff    <= IDX_W'(1);
         hint_ff      <= '0;
         dint_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_ORCHK: begin
               if (19'(htol_ff) > mag_c) begin
                  mode_ff <= MODE_MOVE;
                  hint_ff <= '0;
                  dint_ff <= '0;
               end else begin
                  hint_ff <= sat32(33'(hint_ff) + 33'(err_ff));
               end
            end
            ST_DMOVE: begin
               if (19'(dtol_ff) > dist_ff) begin
                  if (at_final) begin
                     mode_ff <= MODE_GOAL;
                  end else begin
                     mode_ff   <= MODE_ORIENT;
                     target_ff <= target_next;
                  end
                  hint_ff <= '0;
                  dint_ff <= '0;
               end else begin
                  hint_ff <= sat32(33'(hint_ff) + 33'(err_ff));
                  dint_ff <= sat32(33'(dint_ff) + 33'($signed({1'b0, dist_ff})));
               end
            end
            ST_GOAL: begin
               mode_ff <= MODE_GOAL;
               hint_ff <= '0;
               dint_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_fire)
         req_ff <= req_data;
      if (rsp_load) begin
         rsp_data_ff.linear_cmd   <= lin_ff;
         rsp_data_ff.angular_cmd  <= ang_ff;
         rsp_data_ff.mode         <= mode_ff;
         rsp_data_ff.target_index <= 3'(target_ff);
      end
      case (state_ff)
         ST_RD0: begin
            lin_ff <= '0;
            ang_ff <= '0;
         end
         ST_RDT: begin
            px_ff <= 17'(req_ff.odom_x) + 17'($signed(rd_data_ff[31:16]));
            py_ff <= 17'(req_ff.odom_y) + 17'($signed(rd_data_ff[15:0]));
         end
         ST_DIFF: begin
            dx_ff <= 18'($signed(rd_data_ff[31:16])) - 18'(px_ff);
            dy_ff <= 18'($signed(rd_data_ff[15:0])) - 18'(py_ff);
         end
         ST_THETA, ST_SQX, ST_HP, ST_DP: acc_ff <= 60'(mul_p);
         ST_SQY, ST_HI, ST_DI:           acc_ff <= acc_ff + 60'(mul_p);
         ST_CINIT: begin
            // heading from quaternion z, then fold left half-plane by +-pi
            theta_ff <= 18'((acc_ff + 60'sd8192) >>> 14);
            zero_ff  <= (dx_ff == 18'sd0) && (dy_ff == 18'sd0);
            iter_ff  <= '0;
            if (dx_ff < 0) begin
               cz_ff <= (dy_ff >= 0) ? ANG_PI_Q16 : -ANG_PI_Q16;
               cx_ff <= -(34'(dx_ff) <<< 12);
               cy_ff <= -(34'(dy_ff) <<< 12);
            end else begin
               cz_ff <= '0;
               cx_ff <= 34'(dx_ff) <<< 12;
               cy_ff <= 34'(dy_ff) <<< 12;
            end
         end
         ST_CORDIC: begin
            iter_ff <= iter_ff + 1'b1;
            if (cy_ff > 0) begin
               cx_ff <= cx_ff + cy_sh;
               cy_ff <= cy_ff - cx_sh;
               cz_ff <= cz_ff + atan_v;
            end else begin
               cx_ff <= cx_ff - cy_sh;
               cy_ff <= cy_ff + cx_sh;
               cz_ff <= cz_ff - atan_v;
            end
         end
         ST_ERR: err_ff <= err_c;
         ST_ORCHK: begin
            lin_ff <= '0;
            ang_ff <= '0;
         end
         ST_SQINIT: begin
            // dx^2 + dy^2 < 2^36, so start at the top bit pair below that
            sq_v_ff   <= acc_ff[35:0];
            sq_r_ff   <= '0;
            sq_bit_ff <= 36'h1 << 34;
            iter_ff   <= '0;
         end
         ST_SQRT: begin
            iter_ff   <= iter_ff + 1'b1;
            sq_bit_ff <= sq_bit_ff >> 2;
            if (sq_v_ff >= sq_try) begin
               sq_v_ff <= sq_v_ff - sq_try;
               sq_r_ff <= (sq_r_ff >> 1) + sq_bit_ff;
            end else begin
               sq_r_ff <= sq_r_ff >> 1;
            end
            if (last_iter)
               dist_ff <= (sq_v_ff >= sq_try) ? 19'((sq_r_ff >> 1) + sq_bit_ff)
                                              : 19'(sq_r_ff >> 1);
         end
         ST_HOUT: ang_ff <= rnd_sat16(acc_ff);
         ST_DOUT: lin_ff <= rnd_sat16(acc_ff);
         ST_GOAL: begin
            lin_ff <= '0;
            ang_ff <= '0;
         end
         default: ;
      endcase
   end

endmodule

FILE: tb/waypoint_pi_path_controller_top_test.sv
module waypoint_pi_path_controller_top_test
   import wppi_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // ---------------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // ---------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_KP_HEADING;
   logic [23:0] csr_data = '0;

   waypoint_pi_path_controller_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Controller state as predicted by the bench
   // ---------------------------------------------------------------------------
   longint      route_x_q [8];
   longint      route_y_q [8];
   mode_type    cur_mode = MODE_ORIENT;
   logic [2:0]  cur_target = 3'd1;
   longint      head_acc = 0;
   longint      dist_acc = 0;

   // CSR shadow, reset values
   logic [23:0] kp_head = 24'd65536;
   logic [23:0] ki_head = 24'd33;
   logic [23:0] kp_dist = 24'd6554;
   logic [23:0] ki_dist = 24'd1;
   logic [14:0] head_tol = 15'd4;
   logic [14:0] dist_tol = 15'd13;
   logic [14:0] yaw_gain = 15'd8970;
   logic [2:0]  last_wp = 3'd4;

   // atan(2^-i), 2^-16 rad
   longint      atan_q16 [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
                                  128, 64, 32, 16, 8, 4, 2, 1};

   rsp_type     cmd_queue [$];     // expected response words, oldest first
   int          errors = 0;
   int          hold_off = 0;      // receiver hold-off, in cycles
   int          stall_left = 0;
   bit          calm = 1'b0;       // no idling on either side while set

   function automatic longint clamp_s(longint v, int w);
      longint hi;
      hi = (longint'(1) <<< (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   // quaternion z stays within +-1.0 in Q1.14
   function automatic logic signed [15:0] fit_qz(longint v);
      if (v > 16384) return 16'sd16384;
      if (v < -16384) return -16'sd16384;
      return 16'(v);
   endfunction

   // round half up, then shift
   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   // iterative CORDIC bearing, Q3.12 result
   function automatic longint bearing(longint dy, longint dx);
      longint x, y, z, xs, ys;
      if (dx == 0 && dy == 0) return 0;
      x = dx * 4096;
      y = dy * 4096;
      z = 0;
      if (x < 0) begin
         z = (dy >= 0) ? 205887 : -205887;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 17; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; z += atan_q16[i];
         end else begin
            x -= ys; y += xs; z -= atan_q16[i];
         end
      end
      return round_shift(z, 4);
   endfunction

   function automatic longint root_floor(longint val);
      logic [63:0] v, r, b;
      v = val;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   // offset to target and heading error for one odometry word
   function automatic void aim(req_type w, output longint dx, output longint dy,
                               output longint err);
      longint theta;
      dx = route_x_q[cur_target] - (longint'(w.odom_x) + route_x_q[0]);
      dy = route_y_q[cur_target] - (longint'(w.odom_y) + route_y_q[0]);
      theta = round_shift(longint'(w.odom_qz) * longint'(yaw_gain), 14);
      err = bearing(dy, dx) - theta;
   endfunction

   function automatic longint pi_cmd(logic [23:0] kp, logic [23:0] ki, longint e,
                                     longint acc);
      return clamp_s(round_shift(longint'(kp) * e + longint'(ki) * acc, 16), 16);
   endfunction

   // advance the predicted controller by one accepted word
   function automatic void steer_step(req_type w, output bit has, output rsp_type o);
      longint dx, dy, err, range_q, lin, ang;
      lin = 0;
      ang = 0;
      has = 1'b0;
      o = '0;
      if (w.op == OP_LOAD) begin
         route_x_q[w.load_index] = w.load_x;
         route_y_q[w.load_index] = w.load_y;
         return;
      end
      has = 1'b1;
      if (cur_mode == MODE_ORIENT || cur_mode == MODE_MOVE) begin
         aim(w, dx, dy, err);
         if (cur_mode == MODE_ORIENT) begin
            if ((err < 0 ? -err : err) < longint'(head_tol)) begin
               cur_mode = MODE_MOVE;
               head_acc = 0;
               dist_acc = 0;
            end else begin
               head_acc = clamp_s(head_acc + err, 32);
               ang = pi_cmd(kp_head, ki_head, err, head_acc);
            end
         end else begin
            range_q = root_floor(dx * dx + dy * dy);
            if (range_q < longint'(dist_tol)) begin
               if (cur_target == last_wp) begin
                  cur_mode = MODE_GOAL;
               end else begin
                  cur_target = cur_target + 3'd1;
                  cur_mode = MODE_ORIENT;
               end
               head_acc = 0;
               dist_acc = 0;
            end else begin
               head_acc = clamp_s(head_acc + err, 32);
               dist_acc = clamp_s(dist_acc + range_q, 32);
               ang = pi_cmd(kp_head, ki_head, err, head_acc);
               lin = pi_cmd(kp_dist, ki_dist, range_q, dist_acc);
            end
         end
      end else begin
         cur_mode = MODE_GOAL;
         head_acc = 0;
         dist_acc = 0;
      end
      o.linear_cmd   = lin[15:0];
      o.angular_cmd  = ang[15:0];
      o.mode         = cur_mode;
      o.target_index = cur_target;
   endfunction

   // idle lengths: mostly short, now and then long
   function automatic int pick_gap();
      int k;
      k = $urandom_range(0, 99);
      if (k < 80) return $urandom_range(1, 3);
      if (k < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic void report(string what, longint want, longint got);
      errors++;
      if (errors <= 10)
         $display("mismatch %s: expected %0d got %0d", what, want, got);
   endfunction

   // ---------------------------------------------------------------------------
   // Response side: ready pattern and checker
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_ready = 1'b0;
         hold_off--;
      end else if (calm) begin
         rsp_ready = 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ready = 1'b1;
         if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (cmd_queue.size() == 0) begin
            report("unexpected word, target", -1, rsp_data.target_index);
         end else begin
            want = cmd_queue.pop_front();
            if (rsp_data.linear_cmd !== want.linear_cmd)
               report("linear_cmd", want.linear_cmd, rsp_data.linear_cmd);
            if (rsp_data.angular_cmd !== want.angular_cmd)
               report("angular_cmd", want.angular_cmd, rsp_data.angular_cmd);
            if (rsp_data.mode !== want.mode)
               report("mode", want.mode, rsp_data.mode);
            if (rsp_data.target_index !== want.target_index)
               report("target_index", want.target_index, rsp_data.target_index);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------
   task automatic send_word(req_type w);
      int      gap;
      bit      has;
      rsp_type o;
      gap = (calm || $urandom_range(0, 99) >= 30) ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data = w;
      do @(posedge clock); while (!req_ready);
      steer_step(w, has, o);
      if (has) cmd_queue.push_back(o);
   endtask

   // lower valid, wait out every response plus the slowest (move mode) latency
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (cmd_queue.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [23:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_KP_HEADING:  kp_head = val;
         CSR_KI_HEADING:  ki_head = val;
         CSR_KP_DISTANCE: kp_dist = val;
         CSR_KI_DISTANCE: ki_dist = val;
         CSR_HEAD_TOL:    head_tol = val[14:0];
         CSR_DIST_TOL:    dist_tol = val[14:0];
         CSR_YAW_SCALE:   yaw_gain = val[14:0];
         default:         last_wp = val[2:0];
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_all(logic [23:0] kph, logic [23:0] kih, logic [23:0] kpd,
                          logic [23:0] kid, logic [14:0] htol, logic [14:0] dtol,
                          logic [14:0] yaw, logic [2:0] fin);
      drain();
      csr_write(CSR_KP_HEADING, kph);
      csr_write(CSR_KI_HEADING, kih);
      csr_write(CSR_KP_DISTANCE, kpd);
      csr_write(CSR_KI_DISTANCE, kid);
      csr_write(CSR_HEAD_TOL, 24'(htol));
      csr_write(CSR_DIST_TOL, 24'(dtol));
      csr_write(CSR_YAW_SCALE, 24'(yaw));
      csr_write(CSR_FINAL_WP, 24'(fin));
   endtask

   function automatic req_type load_word(logic [2:0] idx, longint x, longint y);
      req_type w;
      w = '0;
      w.op = OP_LOAD;
      w.load_index = idx;
      w.load_x = x[15:0];
      w.load_y = y[15:0];
      w.odom_x = 16'($urandom);   // don't-care fields still toggle
      w.odom_qz = 16'($urandom);
      return w;
   endfunction

   function automatic req_type odom_word(longint x, longint y, longint qz);
      req_type w;
      w = '0;
      w.op = OP_ODOM;
      w.load_index = 3'($urandom);
      w.load_x = 16'($urandom);
      w.load_y = 16'($urandom);
      w.odom_x = 16'(clamp_s(x, 16));
      w.odom_y = 16'(clamp_s(y, 16));
      w.odom_qz = fit_qz(qz);
      return w;
   endfunction

   function automatic longint any_qz();
      return longint'($urandom_range(0, 32768)) - 16384;
   endfunction

   function automatic longint small_coord();
      return longint'($urandom_range(0, 16000)) - 8000;
   endfunction

   // Keep the final waypoint from being reached: a move word that would
   // arrive there gets pushed to the far corner instead.
   function automatic req_type keep_away(req_type w);
      longint dx, dy, err;
      if (w.op == OP_ODOM && cur_mode == MODE_MOVE && cur_target == last_wp) begin
         aim(w, dx, dy, err);
         if (root_floor(dx * dx + dy * dy) < longint'(dist_tol)) begin
            w.odom_x = (route_x_q[cur_target] >= route_x_q[0]) ? -16'sd32768 : 16'sd32767;
            w.odom_y = (route_y_q[cur_target] >= route_y_q[0]) ? -16'sd32768 : 16'sd32767;
         end
      end
      return w;
   endfunction

   // Well-formed drive toward the current target: position near the target or
   // along the way, heading mostly lined up with the bearing.
   task automatic tour(int n, bit guard);
      req_type w;
      longint  bx, by, ox, oy, ex, ey, qz;
      int      sel;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 99) < 6) begin
            w = load_word(3'($urandom), small_coord(), small_coord());
         end else begin
            bx = route_x_q[cur_target] - route_x_q[0];
            by = route_y_q[cur_target] - route_y_q[0];
            sel = $urandom_range(0, 3);
            if (sel == 0) begin
               ox = 0; oy = 0;
            end else if (sel == 1) begin
               ox = longint'($urandom_range(0, 80)) - 40;
               oy = longint'($urandom_range(0, 80)) - 40;
            end else if (sel == 2) begin
               ox = longint'($urandom_range(0, 6000)) - 3000;
               oy = longint'($urandom_range(0, 6000)) - 3000;
            end else begin
               ox = bx - (longint'($urandom_range(0, 65535)) - 32768);
               oy = by - (longint'($urandom_range(0, 65535)) - 32768);
            end
            w = odom_word(bx - ox, by - oy, 0);
            ex = bx - longint'(w.odom_x);
            ey = by - longint'(w.odom_y);
            if ($urandom_range(0, 99) < 70 && yaw_gain != 0)
               qz = bearing(ey, ex) * 16384 / longint'(yaw_gain)
                    + longint'($urandom_range(0, 6)) - 3;
            else
               qz = any_qz();
            w.odom_qz = fit_qz(qz);
         end
         if (guard) w = keep_away(w);
         send_word(w);
      end
   endtask

   // fresh moderate route so far-corner words always stay out of reach
   task automatic load_route();
      for (int i = 0; i < 8; i++)
         send_word(load_word(i[2:0], small_coord(), small_coord()));
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reset values: route extremes, odometry extremes, zero offset bearing.
   task automatic test_reset_defaults();
      send_word(load_word(3'd0, 0, 0));
      send_word(load_word(3'd1, 32767, -32768));
      send_word(load_word(3'd2, -32768, 32767));
      send_word(load_word(3'd3, -1, 1));
      send_word(load_word(3'd4, 0, 0));
      send_word(load_word(3'd5, 256, 0));
      send_word(load_word(3'd6, 0, -256));
      send_word(load_word(3'd7, -32768, -32768));
      send_word(odom_word(-32768, 32767, 16384));
      send_word(odom_word(32767, -32768, -16384));
      send_word(odom_word(32767, 32767, 0));
      send_word(odom_word(-32768, -32768, -1));
      // sitting exactly on the target: zero bearing
      send_word(odom_word(32767, -32768, 0));
      send_word(odom_word(32767, -32768, 0));
      send_word(odom_word(0, 0, 1));
      send_word(odom_word(-1, -1, 16383));
   endtask

   // Gains at both ends; zero tolerance keeps the controller orienting.
   task automatic test_gain_extremes();
      set_all(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 15'd0, 15'd0,
              15'd32767, 3'd7);
      for (int k = 0; k < 30; k++)
         send_word(odom_word(small_coord() * 4, small_coord() * 4, any_qz()));
      set_all(24'd0, 24'd0, 24'd0, 24'd0, 15'd0, 15'd0, 15'd0, 3'd7);
      for (int k = 0; k < 15; k++)
         send_word(odom_word(small_coord(), small_coord(), any_qz()));
   endtask

   // Orient, move and advance through the route under several settings.
   task automatic test_route_tour();
      set_all(24'd65536, 24'd33, 24'd6554, 24'd1, 15'd32767, 15'd2000, 15'd8970, 3'd1);
      load_route();
      tour(250, 1'b1);
      set_all(24'd65536, 24'd33, 24'd6554, 24'd1, 15'd40, 15'd60, 15'd8970, 3'd3);
      tour(300, 1'b1);
      set_all(24'($urandom), 24'($urandom_range(0, 4095)), 24'($urandom),
              24'($urandom_range(0, 4095)), 15'($urandom_range(1, 200)),
              15'($urandom_range(1, 2000)), 15'($urandom_range(1, 32767)),
              3'($urandom_range(1, 7)));
      calm = 1'b1;   // a stretch with no idling on either side
      tour(200, 1'b1);
      calm = 1'b0;
      set_all(24'd131072, 24'd0, 24'd30000, 24'd0, 15'd1, 15'd1, 15'd32767, 3'd6);
      tour(250, 1'b1);
      set_all(24'd40000, 24'd500, 24'd12000, 24'd50, 15'd200, 15'd300, 15'd1, 3'd2);
      tour(200, 1'b1);
   endtask

   // Receiver holds off for a long stretch while words keep coming, so the
   // output register fills and the block stops taking requests.
   task automatic test_backpressure();
      drain();
      hold_off = 500;
      tour(30, 1'b1);
   endtask

   // Unshaped words: random odometry anywhere, random route rewrites.
   task automatic test_noise();
      set_all(24'd65536, 24'd33, 24'd6554, 24'd1, 15'd300, 15'd500, 15'd8970, 3'd5);
      for (int k = 0; k < 400; k++) begin
         if ($urandom_range(0, 99) < 10)
            send_word(keep_away(load_word(3'($urandom), small_coord(), small_coord())));
         else
            send_word(keep_away(odom_word(longint'($urandom_range(0, 65535)) - 32768,
                                          longint'($urandom_range(0, 65535)) - 32768,
                                          any_qz())));
      end
   endtask

   // Widest tolerances: finish the route and stay in goal.
   task automatic test_goal();
      set_all(24'd65536, 24'd33, 24'd6554, 24'd1, 15'd32767, 15'd32767, 15'd8970,
              3'($urandom_range(1, 7)));
      tour(150, 1'b0);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_gain_extremes();
      test_route_tour();
      test_backpressure();
      test_noise();
      test_goal();
      drain();
      if (cmd_queue.size() != 0) report("words still outstanding", 0, cmd_queue.size());
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // hang guard
   initial begin
      #30_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
